>>> rtl/assert_macros.svh
// shared assertion macros, sampled on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CRG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/crg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crg_pkg
// Beat types and fixed constants of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package crg_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam int X_W    = 14;
    localparam int Y_W    = 15;
    localparam int DEC_W  = 18;
    localparam int RAD_W  = 13;
    localparam int LEN_W  = 15;
    localparam int FLD_W  = 16;

    // decision variable constants of the midpoint recurrence
    localparam logic [DEC_W-1:0] DEC_INIT     = 18'd3;
    localparam logic [DEC_W-1:0] DEC_STRAIGHT = 18'd6;
    localparam logic [DEC_W-1:0] DEC_DIAG     = 18'd10;

    localparam logic [2:0] LAST_OCTANT = 3'd7;
    localparam logic [2:0] LAST_SPAN   = 3'd3;

    typedef struct packed {
        logic                    cmd;
        logic signed [FLD_W-1:0] center_x;
        logic signed [FLD_W-1:0] center_y;
        logic [RAD_W-1:0]        radius;
        logic                    fill_mode;
        logic [FLD_W-1:0]        color;
    } in_beat_t;

    typedef struct packed {
        logic signed [FLD_W-1:0] px;
        logic signed [FLD_W-1:0] py;
        logic [LEN_W-1:0]        span_len;
        logic [FLD_W-1:0]        out_color;
        logic                    last_of_step;
        logic                    circle_done;
    } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/circle_raster_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circle_raster_generator_core
// Midpoint circle rasterizer, outline pixels or filled horizontal spans.
// ----------------------------------------------------------------------------
// A start beat latches center, radius, color and mode; each step beat advances
// the decision variable once while the circle runs. An accepted beat is turned
// into a job of 8 outline pixels, 4 fill spans or nothing, and the job is
// played out through the result register one beat per cycle while out_ready
// stays high. The next input beat is taken in the cycle the current job loads
// its last result, which keeps the result channel busy while out_ready stays
// high and input beats that give results keep coming.
module circle_raster_generator_core #(
    parameter int COLOR_BITS = 16,
    parameter int COORD_BITS = 16
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire crg_pkg::in_beat_t   in_data,
    output logic                     out_valid,
    input  wire                      out_ready,
    output crg_pkg::out_beat_t       out_data
);
    import crg_pkg::*;

    // iteration state
    logic [X_W-1:0]        step_x_reg, step_x_next;
    logic [Y_W-1:0]        step_y_reg, step_y_next;
    logic [DEC_W-1:0]      decision_reg, decision_next;
    logic [COORD_BITS-1:0] held_cx_reg, held_cx_next;
    logic [COORD_BITS-1:0] held_cy_reg, held_cy_next;
    logic [COLOR_BITS-1:0] held_color_reg, held_color_next;
    logic                  held_fill_reg, held_fill_next;
    logic                  running_reg, running_next;

    // job being played out
    logic                  job_valid_reg, job_valid_next;
    logic [2:0]            job_idx_reg, job_idx_next;
    logic [X_W-1:0]        job_x_reg, job_x_next;
    logic [Y_W-1:0]        job_y_reg, job_y_next;
    logic [COORD_BITS-1:0] job_cx_reg, job_cx_next;
    logic [COORD_BITS-1:0] job_cy_reg, job_cy_next;
    logic [COLOR_BITS-1:0] job_color_reg, job_color_next;
    logic                  job_fill_reg, job_fill_next;
    logic                  job_done_reg, job_done_next;

    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_data_reg, out_data_next;

    logic                  accept;
    logic                  out_free;
    logic                  emit;
    logic                  job_last;
    logic [2:0]            last_idx;

    // advance datapath
    logic [DEC_W-1:0]      x_ext, y_ext;
    logic [DEC_W-1:0]      adv_d;
    logic [X_W-1:0]        adv_x;
    logic [Y_W-1:0]        adv_y;
    logic                  adv_run;

    // start datapath
    logic [31:0]           cx_wide, cy_wide;
    logic [DEC_W-1:0]      start_d;

    // result datapath
    logic                  swap, neg_x, neg_y;
    logic signed [Y_W-1:0] off_a, off_b;
    logic signed [31:0]    off_a32, off_b32, xoff32, yoff32;
    logic [COORD_BITS-1:0] sum_x, sum_y;
    logic [31:0]           sum_x32, sum_y32, color32;
    logic [LEN_W-1:0]      len_val;

    assign out_free = !out_valid_reg || out_ready;
    assign last_idx = job_fill_reg ? LAST_SPAN : LAST_OCTANT;
    assign job_last = (job_idx_reg == last_idx);
    assign emit     = job_valid_reg && out_free;
    assign in_ready = !job_valid_reg || (out_free && job_last);
    assign accept   = in_valid && in_ready;

    // one midpoint update from the held point
    always_comb
    begin
        x_ext = {{(DEC_W-X_W){1'b0}}, step_x_reg};
        y_ext = {{(DEC_W-Y_W){step_y_reg[Y_W-1]}}, step_y_reg};
        if ($signed(decision_reg) > 0)
        begin
            adv_d = decision_reg + ((x_ext - y_ext) << 2) + DEC_DIAG;
            adv_y = step_y_reg - 1'b1;
        end
        else
        begin
            adv_d = decision_reg + (x_ext << 2) + DEC_STRAIGHT;
            adv_y = step_y_reg;
        end
        adv_x   = step_x_reg + 1'b1;
        adv_run = $signed({adv_y[Y_W-1], adv_y}) >= $signed({2'b00, adv_x});
    end

    assign cx_wide = 32'(in_data.center_x);
    assign cy_wide = 32'(in_data.center_y);
    assign start_d = DEC_INIT - {{(DEC_W-RAD_W-1){1'b0}}, in_data.radius, 1'b0};

    always_comb
    begin
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        decision_next   = decision_reg;
        held_cx_next    = held_cx_reg;
        held_cy_next    = held_cy_reg;
        held_color_next = held_color_reg;
        held_fill_next  = held_fill_reg;
        running_next    = running_reg;

        job_valid_next  = job_valid_reg;
        job_idx_next    = job_idx_reg;
        job_x_next      = job_x_reg;
        job_y_next      = job_y_reg;
        job_cx_next     = job_cx_reg;
        job_cy_next     = job_cy_reg;
        job_color_next  = job_color_reg;
        job_fill_next   = job_fill_reg;
        job_done_next   = job_done_reg;

        if (emit)
        begin
            job_idx_next = job_idx_reg + 1'b1;
            if (job_last)
                job_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (in_data.cmd == CMD_START)
            begin
                held_cx_next    = cx_wide[COORD_BITS-1:0];
                held_cy_next    = cy_wide[COORD_BITS-1:0];
                held_color_next = COLOR_BITS'(in_data.color);
                held_fill_next  = in_data.fill_mode;
                step_x_next     = '0;
                step_y_next     = {{(Y_W-RAD_W){1'b0}}, in_data.radius};
                decision_next   = start_d;
                running_next    = 1'b1;
                if (!in_data.fill_mode)
                begin
                    job_valid_next = 1'b1;
                    job_idx_next   = '0;
                    job_x_next     = '0;
                    job_y_next     = {{(Y_W-RAD_W){1'b0}}, in_data.radius};
                    job_cx_next    = cx_wide[COORD_BITS-1:0];
                    job_cy_next    = cy_wide[COORD_BITS-1:0];
                    job_color_next = COLOR_BITS'(in_data.color);
                    job_fill_next  = 1'b0;
                    job_done_next  = 1'b0;
                end
            end
            else if (running_reg)
            begin
                step_x_next    = adv_x;
                step_y_next    = adv_y;
                decision_next  = adv_d;
                running_next   = adv_run;
                job_valid_next = 1'b1;
                job_idx_next   = '0;
                job_cx_next    = held_cx_reg;
                job_cy_next    = held_cy_reg;
                job_color_next = held_color_reg;
                job_fill_next  = held_fill_reg;
                job_done_next  = !adv_run;
                // fill spans use the point before the update, outline after
                job_x_next     = held_fill_reg ? step_x_reg : adv_x;
                job_y_next     = held_fill_reg ? step_y_reg : adv_y;
            end
        end
    end

    // symmetric point selection for the current result
    always_comb
    begin
        if (job_fill_reg)
        begin
            swap  = job_idx_reg[1];
            neg_x = 1'b1;
            neg_y = job_idx_reg[0];
        end
        else
        begin
            swap  = job_idx_reg[2];
            neg_x = job_idx_reg[0];
            neg_y = job_idx_reg[1];
        end
        off_a   = swap ? job_y_reg : {1'b0, job_x_reg};
        off_b   = swap ? {1'b0, job_x_reg} : job_y_reg;
        off_a32 = 32'(off_a);
        off_b32 = 32'(off_b);
        xoff32  = neg_x ? -off_a32 : off_a32;
        yoff32  = neg_y ? -off_b32 : off_b32;
        sum_x   = job_cx_reg + xoff32[COORD_BITS-1:0];
        sum_y   = job_cy_reg + yoff32[COORD_BITS-1:0];
        sum_x32 = 32'(sum_x);
        sum_y32 = 32'(sum_y);
        color32 = 32'(job_color_reg);
        if (job_fill_reg)
            len_val = swap ? {job_y_reg[Y_W-2:0], 1'b0} : {job_x_reg, 1'b0};
        else
            len_val = LEN_W'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.px           = sum_x32[FLD_W-1:0];
            out_data_next.py           = sum_y32[FLD_W-1:0];
            out_data_next.span_len     = len_val;
            out_data_next.out_color    = color32[FLD_W-1:0];
            out_data_next.last_of_step = job_last;
            out_data_next.circle_done  = job_done_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            decision_reg   <= '0;
            held_cx_reg    <= '0;
            held_cy_reg    <= '0;
            held_color_reg <= '0;
            held_fill_reg  <= 1'b0;
            running_reg    <= 1'b0;
            job_valid_reg  <= 1'b0;
            job_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            decision_reg   <= decision_next;
            held_cx_reg    <= held_cx_next;
            held_cy_reg    <= held_cy_next;
            held_color_reg <= held_color_next;
            held_fill_reg  <= held_fill_next;
            running_reg    <= running_next;
            job_valid_reg  <= job_valid_next;
            job_idx_reg    <= job_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_x_reg     <= job_x_next;
        job_y_reg     <= job_y_next;
        job_cx_reg    <= job_cx_next;
        job_cy_reg    <= job_cy_next;
        job_color_reg <= job_color_next;
        job_fill_reg  <= job_fill_next;
        job_done_reg  <= job_done_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/crg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crg_checker
// Port-level checks of the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crg_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_ready,
    input wire crg_pkg::in_beat_t  in_data,
    input wire                     out_valid,
    input wire                     out_ready,
    input wire crg_pkg::out_beat_t out_data
);
    import crg_pkg::*;

    logic in_beat;
    logic out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // a stalled result beat holds
    `CRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // results of one step stream without gaps
    `CRG_ASSERT_NEXT(a_step_burst, out_beat && !out_data.last_of_step, out_valid)

    // spans are always even, so an odd length is an outline pixel
    `CRG_ASSERT_NOW(a_pixel_len, out_valid && out_data.span_len[0], out_data.span_len == LEN_W'(1))

    // a stalled beat in the middle of a burst keeps the input closed
    `CRG_ASSERT_NOW(a_no_overlap, out_valid && !out_ready && !out_data.last_of_step, !in_beat)

endmodule

bind circle_raster_generator_core crg_checker u_crg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
